FILE: rtl/core/cms_pkg.sv
package cms_pkg;

	// operating modes, encoded as seen on the result stream
	typedef enum logic [3:0] {
		MODE_WAIT_START   = 4'd0,
		MODE_WAIT_TEST    = 4'd1,
		MODE_TEST_FAN1    = 4'd2,
		MODE_TEST_FAN2    = 4'd3,
		MODE_TEST_HEAT    = 4'd4,
		MODE_TEST_COOL    = 4'd5,
		MODE_BEFORE_START = 4'd6,
		MODE_IDLE         = 4'd7,
		MODE_COOL         = 4'd8,
		MODE_HEAT         = 4'd9,
		MODE_ERROR        = 4'd10
	} mode_t;

	// marker for "no mode seen yet" in the dwell-load tracker
	localparam logic [3:0] MODE_NONE = 4'd15;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_COOL_THRESHOLD  = 3'd0,
		REG_HEAT_THRESHOLD  = 3'd1,
		REG_COOL_HYSTERESIS = 3'd2,
		REG_HEAT_HYSTERESIS = 3'd3,
		REG_SKIP_START_WAIT = 3'd4,
		REG_SKIP_SELF_TEST  = 3'd5,
		REG_FAN1_ABSENT     = 3'd6,
		REG_FAN2_ABSENT     = 3'd7
	} reg_index_t;

	localparam int TEMP_W  = 15;
	localparam int HYST_W  = 13;
	localparam int DWELL_W = 15;
	localparam int SUM_W   = TEMP_W + 2;

	// dwell lengths in 100 Hz ticks
	localparam logic [DWELL_W-1:0] DWELL_START  = DWELL_W'(5 * 60 * 100 + 3 * 100);
	localparam logic [DWELL_W-1:0] DWELL_TEST   = DWELL_W'(5 * 100);
	localparam logic [DWELL_W-1:0] DWELL_FAN    = DWELL_W'(2 * 60 * 100);
	localparam logic [DWELL_W-1:0] DWELL_COOL_T = DWELL_W'(3 * 60 * 100);
	localparam logic [DWELL_W-1:0] DWELL_BEFORE = DWELL_W'(30 * 100);

	// reset values of the configuration registers
	localparam logic [TEMP_W-1:0] COOL_THRESHOLD_RST  = TEMP_W'(3000);
	localparam logic [TEMP_W-1:0] HEAT_THRESHOLD_RST  = TEMP_W'(500);
	localparam logic [HYST_W-1:0] COOL_HYSTERESIS_RST = HYST_W'(200);
	localparam logic [HYST_W-1:0] HEAT_HYSTERESIS_RST = HYST_W'(200);

endpackage

FILE: rtl/core/climate_mode_sequencer_unit.sv
// climate mode sequencer
// one input transaction per 100 Hz tick on the s_ group: temperature in
// centidegrees and a fault flag. each accepted tick yields exactly one
// result transaction on the m_ group: the new mode and the self-test flag.
// the mode update is computed from the accepted tick and the held state,
// and lands in the output register on the edge that accepts the tick.
// throughput is one tick per cycle while the receiver takes each result;
// the state and output registers are written together, so nothing else limits it.
// s_tready stays high while the output register is empty or being drained,
// so a new tick is taken in the same cycle the previous result is taken.
// when the receiver stalls, the result holds in the output register and
// s_tready drops until it is taken.
// configuration is a plain write port (cfg_wen, cfg_index, cfg_wdata); the user
// must write it only while the block is idle, the block does not enforce this.
// asynchronous reset sets the mode to wait_start, clears the dwell timer and
// the self-test flag, marks no mode as seen, loads the default thresholds
// and empties the output register.
module climate_mode_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [14:0] temperature, [15] fault_active
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [3:0] mode_now, [4] self_test_done, [7:5] zero
	input  logic        cfg_wen,
	input  cms_pkg::reg_index_t cfg_index,
	input  logic [14:0] cfg_wdata
);
	import cms_pkg::*;

	// configuration registers
	logic signed [TEMP_W-1:0] cool_thr_q, heat_thr_q;
	logic [HYST_W-1:0]        cool_hyst_q, heat_hyst_q;
	logic skip_wait_q, skip_test_q, fan1_absent_q, fan2_absent_q;

	// sequencer state
	mode_t              mode_q;
	logic [3:0]         mode_seen_q;
	logic [DWELL_W-1:0] dwell_q;
	logic               done_q;

	// next state
	mode_t              mode_d;
	logic [DWELL_W-1:0] dwell_d;
	logic               done_d;

	// output register
	logic [3:0] out_mode_q;
	logic       out_done_q;

	logic s_fire;
	logic signed [TEMP_W-1:0] temp;
	logic fault;
	logic signed [SUM_W-1:0] temp_x, cool_lo, heat_hi;

	assign s_tready = !m_tvalid || m_tready;
	assign s_fire   = s_tvalid && s_tready;
	assign temp     = $signed(s_tdata[14:0]);
	assign fault    = s_tdata[15];

	// thermostat bounds, exact wide signed values
	assign temp_x  = SUM_W'(temp);
	assign cool_lo = SUM_W'(cool_thr_q) - $signed({{(SUM_W-HYST_W){1'b0}}, cool_hyst_q});
	assign heat_hi = SUM_W'(heat_thr_q) + $signed({{(SUM_W-HYST_W){1'b0}}, heat_hyst_q});

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cool_thr_q    <= COOL_THRESHOLD_RST;
			heat_thr_q    <= HEAT_THRESHOLD_RST;
			cool_hyst_q   <= COOL_HYSTERESIS_RST;
			heat_hyst_q   <= HEAT_HYSTERESIS_RST;
			skip_wait_q   <= 1'b0;
			skip_test_q   <= 1'b0;
			fan1_absent_q <= 1'b0;
			fan2_absent_q <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_COOL_THRESHOLD:  cool_thr_q    <= cfg_wdata;
				REG_HEAT_THRESHOLD:  heat_thr_q    <= cfg_wdata;
				REG_COOL_HYSTERESIS: cool_hyst_q   <= cfg_wdata[HYST_W-1:0];
				REG_HEAT_HYSTERESIS: heat_hyst_q   <= cfg_wdata[HYST_W-1:0];
				REG_SKIP_START_WAIT: skip_wait_q   <= cfg_wdata[0];
				REG_SKIP_SELF_TEST:  skip_test_q   <= cfg_wdata[0];
				REG_FAN1_ABSENT:     fan1_absent_q <= cfg_wdata[0];
				REG_FAN2_ABSENT:     fan2_absent_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// next mode: dwell load, countdown or sequence step, thermostat, fault
	always_comb begin
		mode_d  = mode_q;
		dwell_d = dwell_q;
		done_d  = done_q;

		// load the dwell timer on the first tick in a new mode
		if (mode_seen_q != mode_q) begin
			case (mode_q)
				MODE_WAIT_START:   dwell_d = (skip_wait_q || done_q) ? '0 : DWELL_START;
				MODE_WAIT_TEST:    dwell_d = DWELL_TEST;
				MODE_TEST_FAN1,
				MODE_TEST_FAN2,
				MODE_TEST_HEAT:    dwell_d = DWELL_FAN;
				MODE_TEST_COOL:    dwell_d = DWELL_COOL_T;
				MODE_BEFORE_START: dwell_d = DWELL_BEFORE;
				default: ;
			endcase
		end

		if (dwell_d != '0) begin
			dwell_d = dwell_d - DWELL_W'(1);
		end else begin
			case (mode_q)
				MODE_WAIT_START: begin
					mode_d = (skip_test_q || done_q) ? MODE_BEFORE_START : MODE_WAIT_TEST;
				end
				MODE_WAIT_TEST: begin
					if (!fan1_absent_q)
						mode_d = MODE_TEST_FAN1;
					else if (!fan2_absent_q)
						mode_d = MODE_TEST_FAN2;
					else
						mode_d = MODE_TEST_HEAT;
				end
				MODE_TEST_FAN1: begin
					mode_d = fan2_absent_q ? MODE_TEST_HEAT : MODE_TEST_FAN2;
				end
				MODE_TEST_FAN2: mode_d = MODE_TEST_HEAT;
				MODE_TEST_HEAT: mode_d = MODE_TEST_COOL;
				MODE_TEST_COOL: begin
					mode_d = MODE_BEFORE_START;
					done_d = 1'b1;
				end
				MODE_BEFORE_START: mode_d = MODE_IDLE;
				default: ;
			endcase
		end

		// hysteresis thermostat, heat test wins over cool from idle
		if (mode_d == MODE_IDLE) begin
			if (temp > cool_thr_q) mode_d = MODE_COOL;
			if (temp < heat_thr_q) mode_d = MODE_HEAT;
		end
		if (mode_d == MODE_COOL && temp_x < cool_lo) mode_d = MODE_IDLE;
		if (mode_d == MODE_HEAT && temp_x > heat_hi) mode_d = MODE_IDLE;

		// fault override
		if (fault)
			mode_d = MODE_ERROR;
		else if (mode_d == MODE_ERROR)
			mode_d = MODE_IDLE;
	end

	// state update per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_WAIT_START;
			mode_seen_q <= MODE_NONE;
			dwell_q     <= '0;
			done_q      <= 1'b0;
		end else if (s_fire) begin
			mode_q      <= mode_d;
			mode_seen_q <= mode_q;
			dwell_q     <= dwell_d;
			done_q      <= done_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (s_tready)
			m_tvalid <= s_tvalid;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			out_mode_q <= mode_d;
			out_done_q <= done_d;
		end
	end

	assign m_tdata = {3'b000, out_done_q, out_mode_q};

endmodule

FILE: bench/mode_result_checker.sv
module mode_result_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [15:0]         s_tdata,   // [14:0] temperature, [15] fault_active
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [7:0]          m_tdata,   // [3:0] mode_now, [4] self_test_done, [7:5] zero
	input  logic                cfg_wen,
	input  cms_pkg::reg_index_t cfg_index,
	input  logic [14:0]         cfg_wdata,
	output int                  fail_count,
	output int                  backlog
);
	import cms_pkg::*;

	// dwell lengths in ticks
	localparam logic [14:0] START_TICKS     = 15'd30300;
	localparam logic [14:0] TEST_WAIT_TICKS = 15'd500;
	localparam logic [14:0] FAN_TICKS       = 15'd12000;
	localparam logic [14:0] COOL_TEST_TICKS = 15'd18000;
	localparam logic [14:0] SETTLE_TICKS    = 15'd3000;
	localparam logic [3:0]  NO_MODE         = 4'hF;

	typedef struct {
		mode_t mode;
		logic  done;
	} tick_result_t;

	tick_result_t expected_modes[$];
	tick_result_t want;
	int fails = 0;

	// shadow of the mode state
	mode_t       mode_q;
	logic [3:0]  seen_q;
	logic [14:0] dwell_q;
	logic        done_q;

	// shadow of the configuration
	logic signed [14:0] cool_thr;
	logic signed [14:0] heat_thr;
	logic [12:0]        cool_hyst;
	logic [12:0]        heat_hyst;
	logic               skip_wait;
	logic               skip_test;
	logic               fan1_gone;
	logic               fan2_gone;

	// one tick of the sequencer: dwell load, countdown or step, thermostat, fault
	function automatic tick_result_t next_mode(input logic [14:0] temp, input logic fault);
		tick_result_t res;
		int t;
		int cool_lo;
		int heat_hi;
		t = int'(signed'(temp));
		cool_lo = int'(cool_thr) - int'(cool_hyst);
		heat_hi = int'(heat_thr) + int'(heat_hyst);

		if (seen_q != mode_q) begin
			case (mode_q)
				MODE_WAIT_START: begin
					if (skip_wait || done_q)
						dwell_q = '0;
					else
						dwell_q = START_TICKS;
				end
				MODE_WAIT_TEST: dwell_q = TEST_WAIT_TICKS;
				MODE_TEST_FAN1, MODE_TEST_FAN2, MODE_TEST_HEAT: dwell_q = FAN_TICKS;
				MODE_TEST_COOL: dwell_q = COOL_TEST_TICKS;
				MODE_BEFORE_START: dwell_q = SETTLE_TICKS;
				default: ;
			endcase
			seen_q = mode_q;
		end

		if (dwell_q != '0) begin
			dwell_q = dwell_q - 15'd1;
		end else begin
			case (mode_q)
				MODE_WAIT_START: begin
					if (skip_test || done_q)
						mode_q = MODE_BEFORE_START;
					else
						mode_q = MODE_WAIT_TEST;
				end
				MODE_WAIT_TEST: begin
					mode_q = MODE_TEST_FAN1;
					if (fan1_gone) begin
						mode_q = MODE_TEST_FAN2;
						if (fan2_gone)
							mode_q = MODE_TEST_HEAT;
					end
				end
				MODE_TEST_FAN1: begin
					mode_q = MODE_TEST_FAN2;
					if (fan2_gone)
						mode_q = MODE_TEST_HEAT;
				end
				MODE_TEST_FAN2: mode_q = MODE_TEST_HEAT;
				MODE_TEST_HEAT: mode_q = MODE_TEST_COOL;
				MODE_TEST_COOL: begin
					mode_q = MODE_BEFORE_START;
					done_q = 1'b1;
				end
				MODE_BEFORE_START: mode_q = MODE_IDLE;
				default: ;
			endcase
		end

		// thermostat, heat wins over cool when both hold
		if (mode_q == MODE_IDLE) begin
			if (t > int'(cool_thr))
				mode_q = MODE_COOL;
			if (t < int'(heat_thr))
				mode_q = MODE_HEAT;
		end
		if (mode_q == MODE_COOL && t < cool_lo)
			mode_q = MODE_IDLE;
		if (mode_q == MODE_HEAT && t > heat_hi)
			mode_q = MODE_IDLE;

		// fault override, cleared fault drops back to idle
		if (fault)
			mode_q = MODE_ERROR;
		else if (mode_q == MODE_ERROR)
			mode_q = MODE_IDLE;

		res.mode = mode_q;
		res.done = done_q;
		return res;
	endfunction

	// watch config writes and both stream channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = MODE_WAIT_START;
			seen_q = NO_MODE;
			dwell_q = '0;
			done_q = 1'b0;
			cool_thr = 15'sd3000;
			heat_thr = 15'sd500;
			cool_hyst = 13'd200;
			heat_hyst = 13'd200;
			skip_wait = 1'b0;
			skip_test = 1'b0;
			fan1_gone = 1'b0;
			fan2_gone = 1'b0;
			expected_modes.delete();
			fail_count <= fails;
			backlog <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_COOL_THRESHOLD:  cool_thr = cfg_wdata;
					REG_HEAT_THRESHOLD:  heat_thr = cfg_wdata;
					REG_COOL_HYSTERESIS: cool_hyst = cfg_wdata[12:0];
					REG_HEAT_HYSTERESIS: heat_hyst = cfg_wdata[12:0];
					REG_SKIP_START_WAIT: skip_wait = cfg_wdata[0];
					REG_SKIP_SELF_TEST:  skip_test = cfg_wdata[0];
					REG_FAN1_ABSENT:     fan1_gone = cfg_wdata[0];
					REG_FAN2_ABSENT:     fan2_gone = cfg_wdata[0];
					default: ;
				endcase
			end

			// result transaction against the oldest expectation
			if (m_tvalid && m_tready) begin
				if (expected_modes.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual mode %0d done %0b",
						$time, m_tdata[3:0], m_tdata[4]);
					fails++;
				end else begin
					want = expected_modes.pop_front();
					if (m_tdata[3:0] !== want.mode) begin
						$display("%0t: mode_now expected %0d actual %0d",
							$time, want.mode, m_tdata[3:0]);
						fails++;
					end
					if (m_tdata[4] !== want.done) begin
						$display("%0t: self_test_done expected %0b actual %0b",
							$time, want.done, m_tdata[4]);
						fails++;
					end
					if (m_tdata[7:5] !== 3'b000) begin
						$display("%0t: padding expected 0 actual %0d", $time, m_tdata[7:5]);
						fails++;
					end
				end
			end

			// tick transaction in
			if (s_tvalid && s_tready)
				expected_modes.push_back(next_mode(s_tdata[14:0], s_tdata[15]));

			fail_count <= fails;
			backlog <= expected_modes.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
module tb_top;
	import cms_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [14:0] temperature, [15] fault_active
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [3:0] mode_now, [4] self_test_done, [7:5] zero
	logic        cfg_wen;
	reg_index_t  cfg_index;
	logic [14:0] cfg_wdata;

	int fail_count;
	int backlog;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;

	// current thresholds, used to aim temperatures at the switching points
	int cfg_cool;
	int cfg_heat;
	int cfg_chys;
	int cfg_hhys;

	climate_mode_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	mode_result_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.backlog    (backlog)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#40_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = 200;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	function automatic void set_idling(input int kind);
		case (kind)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
			default: begin send_idle_pct = 20; recv_stall_pct = 20; end
		endcase
	endfunction

	// one tick transaction, called and returning at a falling edge
	task automatic send_tick(input int temp, input bit fault);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {fault, 15'(temp)};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// stop offering and wait for every result to come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (backlog != 0);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [14:0] value);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	task automatic write_settings(input int cool, input int heat, input int chys,
			input int hhys, input bit ssw, input bit sst, input bit f1, input bit f2);
		cfg_cool = int'(signed'(15'(cool)));
		cfg_heat = int'(signed'(15'(heat)));
		cfg_chys = chys;
		cfg_hhys = hhys;
		write_reg(REG_COOL_THRESHOLD, 15'(cool));
		write_reg(REG_HEAT_THRESHOLD, 15'(heat));
		write_reg(REG_COOL_HYSTERESIS, 15'(chys));
		write_reg(REG_HEAT_HYSTERESIS, 15'(hhys));
		write_reg(REG_SKIP_START_WAIT, 15'(ssw));
		write_reg(REG_SKIP_SELF_TEST, 15'(sst));
		write_reg(REG_FAN1_ABSENT, 15'(f1));
		write_reg(REG_FAN2_ABSENT, 15'(f2));
		cfg_wen <= 1'b0;
	endtask

	// temperatures mostly around the four switching points
	function automatic int pick_temp();
		int r;
		int spread;
		int base;
		r = $urandom_range(0, 99);
		spread = ($urandom_range(0, 3) == 0) ? 300 : 3;
		if (r < 20)
			base = cfg_cool;
		else if (r < 40)
			base = cfg_cool - cfg_chys;
		else if (r < 55)
			base = cfg_heat;
		else if (r < 70)
			base = cfg_heat + cfg_hhys;
		else if (r < 90)
			return int'($urandom_range(0, 14000)) - 5000;
		else
			return int'($urandom_range(0, 32767));
		return base + int'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	// stimulus and verdict
	initial begin
		bit ssw;
		bit sst;
		bit f1;
		bit f2;
		int seq_ticks;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_COOL_THRESHOLD;
		cfg_wdata = '0;
		hold_req = 1'b0;
		set_idling(0);
		cfg_cool = 3000;
		cfg_heat = 500;
		cfg_chys = 200;
		cfg_hhys = 200;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// opening of the start-up sequence, fault free, random test options
		ssw = 1'($urandom_range(0, 1));
		sst = ($urandom_range(0, 3) == 0);
		f1 = 1'($urandom_range(0, 1));
		f2 = 1'($urandom_range(0, 1));
		write_settings(3000, 500, 200, 200, ssw, sst, f1, f2);
		// long enough to pass the test wait and the fan skips when the start wait is skipped
		seq_ticks = 520;
		set_idling(3);
		repeat (seq_ticks) send_tick(int'($urandom_range(0, 32767)), 1'b0);
		drain();

		// directed: fault entry and exit, threshold edges, field extremes
		set_idling(1);
		send_tick(0, 1'b1);
		send_tick(-16384, 1'b1);
		send_tick(1000, 1'b0);
		send_tick(3001, 1'b0);
		send_tick(3000, 1'b0);
		send_tick(2800, 1'b0);
		send_tick(2799, 1'b0);
		send_tick(3000, 1'b0);
		send_tick(16383, 1'b0);
		send_tick(-16384, 1'b0);
		send_tick(499, 1'b0);
		send_tick(700, 1'b0);
		send_tick(701, 1'b0);
		send_tick(500, 1'b0);
		send_tick(-5000, 1'b0);
		send_tick(9000, 1'b0);
		send_tick(9000, 1'b1);
		send_tick(9000, 1'b0);
		send_tick(9000, 1'b0);
		send_tick(100, 1'b1);
		send_tick(-1, 1'b0);
		drain();

		// random phases, each with its own settings and idling
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_settings(3000, 500, 200, 200, 1, 1, 1, 1);
				1: write_settings(9000, -5000, 5000, 5000, 0, 0, 0, 0);
				2: write_settings(-5000, 9000, 0, 0, 1, 0, 1, 0);
				4: write_settings(16383, -16384, 8191, 8191, 0, 1, 0, 1);
				5: write_settings(-16384, 16383, 8191, 0, 1, 1, 0, 0);
				7: write_settings(int'($urandom_range(0, 14000)) - 5000,
					int'($urandom_range(0, 14000)) - 5000,
					int'($urandom_range(0, 100)), int'($urandom_range(0, 100)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				default: write_settings(int'($urandom_range(0, 14000)) - 5000,
					int'($urandom_range(0, 14000)) - 5000,
					int'($urandom_range(0, 5000)), int'($urandom_range(0, 5000)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			endcase
			set_idling(ph % 4);
			// long receiver hold-off while ticks keep coming
			if (ph == 0)
				hold_req = 1'b1;
			repeat (140) send_tick(pick_temp(), $urandom_range(0, 99) < 4);
			drain();
		end

		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: climate_mode_sequencer_unit.f
rtl/core/cms_pkg.sv
rtl/core/climate_mode_sequencer_unit.sv
bench/mode_result_checker.sv
bench/tb_top.sv
